### hdl/fbdr_pkg.sv
// ----------------------------------------------------------------------------
// fbdr_pkg
// Shared constants, register codes and stage side-band types of the
// flat-bottom distance restraint pipeline.
// ----------------------------------------------------------------------------
package fbdr_pkg;

  localparam int ATOM_BITS_DEF = 16;
  localparam int CFG_DATA_W    = 32;
  localparam int CFG_IDX_W     = 3;
  localparam int SQRT_STAGES   = 32;
  localparam int DIV_STEPS     = 47;

  localparam logic [46:0] MAG_MAX = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LOWER_BOUND  = 3'd0,
    REG_LINEAR_ONSET = 3'd1,
    REG_FORCE_CONST  = 3'd2,
    REG_REPULSIVE    = 3'd3,
    REG_FIRST_ATOM   = 3'd4,
    REG_SECOND_ATOM  = 3'd5
  } cfg_reg_t;

  // Geometry that travels beside the square root.
  typedef struct packed {
    logic            big;
    logic [2:0]      dsgn;
    logic [2:0][32:0] dm;
  } geo_t;

  // Energy and force signs that travel beside the dividers.
  typedef struct packed {
    logic [46:0] energy;
    logic [2:0]  neg;
  } div_side_t;

endpackage

### hdl/fbdr_in_if.sv
// ----------------------------------------------------------------------------
// fbdr_in_if
// Input channel: positions of the two restrained atoms.
// ----------------------------------------------------------------------------
interface fbdr_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] first_x;
  logic signed [31:0] first_y;
  logic signed [31:0] first_z;
  logic signed [31:0] second_x;
  logic signed [31:0] second_y;
  logic signed [31:0] second_z;

  modport source (output valid, first_x, first_y, first_z, second_x, second_y, second_z,
                  input ready);
  modport sink (input valid, first_x, first_y, first_z, second_x, second_y, second_z,
                output ready);
endinterface

### hdl/fbdr_out_if.sv
// ----------------------------------------------------------------------------
// fbdr_out_if
// Result channel: one force beat per atom, energy on the first beat.
// ----------------------------------------------------------------------------
interface fbdr_out_if import fbdr_pkg::*; #(
  parameter int ATOM_INDEX_BITS = ATOM_BITS_DEF
);
  logic                       valid;
  logic                       ready;
  logic [ATOM_INDEX_BITS-1:0] atom_index;
  logic signed [47:0]         force_x;
  logic signed [47:0]         force_y;
  logic signed [47:0]         force_z;
  logic [46:0]                energy;
  logic                       last;

  modport source (output valid, atom_index, force_x, force_y, force_z, energy, last,
                  input ready);
  modport sink (input valid, atom_index, force_x, force_y, force_z, energy, last,
                output ready);
endinterface

### hdl/fbdr_sqrt.sv
// ----------------------------------------------------------------------------
// fbdr_sqrt
// Pipelined integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
module fbdr_sqrt import fbdr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        in_valid,
  input  logic [63:0] in_rad,
  input  geo_t        in_side,
  output logic        out_valid,
  output logic [31:0] out_root,
  output geo_t        out_side
);

  typedef struct packed {
    logic [63:0] rad;
    logic [33:0] rem;
    logic [31:0] root;
    geo_t        side;
  } sq_stage_t;

  sq_stage_t              stg_r   [SQRT_STAGES];
  sq_stage_t              stg_nxt [SQRT_STAGES];
  sq_stage_t              seed;
  logic [SQRT_STAGES-1:0] vld_r;

  function automatic sq_stage_t sq_step(sq_stage_t s);
    logic [35:0] rem2;
    logic [35:0] trial;
    sq_stage_t   o;
    o     = s;
    rem2  = {s.rem, s.rad[63:62]};
    trial = {2'b00, s.root, 2'b01};
    o.rad = {s.rad[61:0], 2'b00};
    if (rem2 >= trial) begin
      o.rem  = 34'(rem2 - trial);
      o.root = {s.root[30:0], 1'b1};
    end else begin
      o.rem  = rem2[33:0];
      o.root = {s.root[30:0], 1'b0};
    end
    return o;
  endfunction

  always_comb begin
    seed.rad  = in_rad;
    seed.rem  = '0;
    seed.root = '0;
    seed.side = in_side;
    stg_nxt[0] = sq_step(seed);
    for (int k = 1; k < SQRT_STAGES; k++) begin
      stg_nxt[k] = sq_step(stg_r[k-1]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[SQRT_STAGES-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      stg_r <= stg_nxt;
    end
  end

  assign out_valid = vld_r[SQRT_STAGES-1];
  assign out_root  = stg_r[SQRT_STAGES-1].root;
  assign out_side  = stg_r[SQRT_STAGES-1].side;

endmodule

### hdl/fbdr_div.sv
// ----------------------------------------------------------------------------
// fbdr_div
// Three-lane pipelined restoring divider with saturation to 47 bits.
// ----------------------------------------------------------------------------
module fbdr_div import fbdr_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_valid,
  input  logic [2:0][82:0] in_prod,
  input  logic [32:0]      in_den,
  input  div_side_t        in_side,
  output logic             out_valid,
  output logic [2:0][46:0] out_mag,
  output div_side_t        out_side
);

  localparam int NSTG = DIV_STEPS + 1;

  typedef struct packed {
    logic [2:0][32:0] rem;
    logic [2:0][46:0] low;
    logic [2:0][46:0] quo;
    logic [2:0]       ovf;
    logic             zero;
    logic [32:0]      den;
    div_side_t        side;
  } dv_stage_t;

  dv_stage_t       stg_r   [NSTG];
  dv_stage_t       stg_nxt [NSTG];
  logic [NSTG-1:0] vld_r;

  function automatic dv_stage_t dv_step(dv_stage_t s);
    logic [33:0] rem2;
    dv_stage_t   o;
    o = s;
    for (int i = 0; i < 3; i++) begin
      rem2     = {s.rem[i], s.low[i][46]};
      o.low[i] = {s.low[i][45:0], 1'b0};
      if (rem2 >= {1'b0, s.den}) begin
        o.rem[i] = 33'(rem2 - {1'b0, s.den});
        o.quo[i] = {s.quo[i][45:0], 1'b1};
      end else begin
        o.rem[i] = rem2[32:0];
        o.quo[i] = {s.quo[i][45:0], 1'b0};
      end
    end
    return o;
  endfunction

  // The first stage flags quotients that overflow 47 bits, so the remaining
  // steps only ever see a partial remainder below the divisor.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      stg_nxt[0].ovf[i] = in_prod[i][82:47] >= {3'b000, in_den};
      stg_nxt[0].rem[i] = in_prod[i][79:47];
      stg_nxt[0].low[i] = in_prod[i][46:0];
      stg_nxt[0].quo[i] = '0;
    end
    stg_nxt[0].zero = (in_den == '0);
    stg_nxt[0].den  = in_den;
    stg_nxt[0].side = in_side;
    for (int k = 1; k < NSTG; k++) begin
      stg_nxt[k] = dv_step(stg_r[k-1]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NSTG-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      stg_r <= stg_nxt;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (stg_r[NSTG-1].zero) begin
        out_mag[i] = '0;
      end else if (stg_r[NSTG-1].ovf[i]) begin
        out_mag[i] = MAG_MAX;
      end else begin
        out_mag[i] = stg_r[NSTG-1].quo[i];
      end
    end
  end

  assign out_valid = vld_r[NSTG-1];
  assign out_side  = stg_r[NSTG-1].side;

endmodule

### hdl/flat_bottom_distance_restraint.sv
// ----------------------------------------------------------------------------
// flat_bottom_distance_restraint
// Flat-bottom harmonic/linear distance restraint between two atoms.
// ----------------------------------------------------------------------------
// Usage: each input beat carries the Q16.16 positions of two atoms. For every
// input beat the block sends two result beats: first the force on the atom
// named by first_atom, carrying the restraint energy, then the equal and
// opposite force on second_atom with energy zero and last high.
// Configuration is written through cfg_we/cfg_index/cfg_data while the block
// is idle; unknown indexes are ignored.
// Order: the first result beat is presented from the output register once the
// pair has crossed the pipeline, the second in the cycle after the receiver
// takes the first.
// Throughput: the sustained input rate is limited by the result port, which
// carries two beats per pair; the 89-stage pipeline itself takes a beat in
// every cycle unless stalled, and absorbs bursts.
// Reset zeroes the configuration and valid registers and empties the pipeline.
// When the receiver stalls, the whole pipeline holds in place once a
// finished pair waits at its end; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module flat_bottom_distance_restraint import fbdr_pkg::*; #(
  parameter int ATOM_INDEX_BITS = ATOM_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  fbdr_in_if.sink               in_ch,
  fbdr_out_if.source            out_ch
);

  // Configuration registers.
  logic signed [31:0]         lower_bound_r;
  logic signed [31:0]         linear_onset_r;
  logic [31:0]                force_const_r;
  logic                       repulsive_r;
  logic [ATOM_INDEX_BITS-1:0] first_atom_r;
  logic [ATOM_INDEX_BITS-1:0] second_atom_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lower_bound_r  <= '0;
      linear_onset_r <= '0;
      force_const_r  <= '0;
      repulsive_r    <= 1'b0;
      first_atom_r   <= '0;
      second_atom_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_LOWER_BOUND:  lower_bound_r  <= cfg_data;
        REG_LINEAR_ONSET: linear_onset_r <= cfg_data;
        REG_FORCE_CONST:  force_const_r  <= cfg_data;
        REG_REPULSIVE:    repulsive_r    <= cfg_data[0];
        REG_FIRST_ATOM:   first_atom_r   <= cfg_data[ATOM_INDEX_BITS-1:0];
        REG_SECOND_ATOM:  second_atom_r  <= cfg_data[ATOM_INDEX_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Global advance. The pipeline moves whenever the output stage can take
  // the pair at its end or that end holds no pair.
  logic en;
  logic out_free;
  logic dv_last;
  logic out_valid_r;
  logic out_second_r;

  assign out_free    = !out_valid_r || (out_second_r && out_ch.ready);
  assign en          = out_free || !dv_last;
  assign in_ch.ready = en;

  // Stage 1: per-axis differences, magnitudes and the halving flag for
  // separations of 2^31 or more.
  logic signed [31:0] pa [3];
  logic signed [31:0] pb [3];
  logic signed [32:0] d_c [3];
  geo_t               g1_nxt;
  geo_t               g1_r;
  logic               v1_r;

  assign pa[0] = in_ch.first_x;
  assign pa[1] = in_ch.first_y;
  assign pa[2] = in_ch.first_z;
  assign pb[0] = in_ch.second_x;
  assign pb[1] = in_ch.second_y;
  assign pb[2] = in_ch.second_z;

  always_comb begin
    g1_nxt.big = 1'b0;
    for (int i = 0; i < 3; i++) begin
      d_c[i]         = 33'(pa[i]) - 33'(pb[i]);
      g1_nxt.dsgn[i] = d_c[i][32];
      g1_nxt.dm[i]   = d_c[i][32] ? 33'(-d_c[i]) : d_c[i];
    end
    for (int i = 0; i < 3; i++) begin
      g1_nxt.big = g1_nxt.big | g1_nxt.dm[i][32] | g1_nxt.dm[i][31];
    end
  end

  // Stage 2: squares of the (possibly halved) magnitudes.
  logic [31:0]        m_c   [3];
  logic [63:0]        sqw_c [3];
  logic [2:0][62:0]   sq_r;
  geo_t               g2_r;
  logic               v2_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      m_c[i]   = g1_r.big ? g1_r.dm[i][32:1] : g1_r.dm[i][31:0];
      sqw_c[i] = {32'b0, m_c[i]} * {32'b0, m_c[i]};
    end
  end

  // Stage 3: sum of squares feeding the root pipeline.
  logic [63:0] sum_r;
  geo_t        g3_r;
  logic        v3_r;

  logic        sq_valid;
  logic [31:0] sq_root;
  geo_t        sq_side;

  fbdr_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v3_r),
    .in_rad    (sum_r),
    .in_side   (g3_r),
    .out_valid (sq_valid),
    .out_root  (sq_root),
    .out_side  (sq_side)
  );

  // Stage 4: distance, region decision and the lever for the spring.
  // In the harmonic region the lever is the excursion past the bound; in the
  // linear region it is the fixed span between the bound and the onset.
  typedef struct packed {
    logic        active;
    logic        harm;
    logic        dneg;
    logic [33:0] a;
    logic [33:0] t;
    logic [32:0] r;
    geo_t        g;
  } reg_st_t;

  logic [32:0]        r_c;
  logic signed [34:0] rr_c;
  logic signed [34:0] r0e_c;
  logic signed [34:0] r1e_c;
  logic signed [34:0] x_c;
  logic signed [34:0] lev_c;
  logic signed [34:0] t_c;
  logic [34:0]        lm_c;
  reg_st_t            st4_nxt;
  reg_st_t            st4_r;
  logic               v4_r;

  always_comb begin
    r_c   = sq_side.big ? {sq_root, 1'b0} : {1'b0, sq_root};
    rr_c  = signed'({2'b00, r_c});
    r0e_c = 35'(lower_bound_r);
    r1e_c = 35'(linear_onset_r);
    x_c   = repulsive_r ? (-r0e_c - rr_c) : (rr_c - r0e_c);
    lev_c = repulsive_r ? (-r0e_c - r1e_c) : (r1e_c - r0e_c);
    t_c   = repulsive_r ? (r1e_c - rr_c) : (rr_c - r1e_c);
    lm_c  = lev_c[34] ? 35'(-lev_c) : lev_c;
    st4_nxt.active = repulsive_r ? (rr_c < -r0e_c) : (rr_c > r0e_c);
    st4_nxt.harm   = repulsive_r ? (rr_c > r1e_c) : (rr_c < r1e_c);
    st4_nxt.dneg   = st4_nxt.active && !st4_nxt.harm && lev_c[34];
    st4_nxt.a      = st4_nxt.harm ? x_c[33:0] : lm_c[33:0];
    st4_nxt.t      = t_c[33:0];
    st4_nxt.r      = r_c;
    st4_nxt.g      = sq_side;
  end

  // Stage 5: dE/dr = k * lever in Q34.16; zero outside the active region.
  logic [65:0] kprod_c;
  logic [49:0] dedr_nxt;
  logic [49:0] dedr_r;
  reg_st_t     st5_r;
  logic        v5_r;

  assign kprod_c  = {34'b0, force_const_r} * {32'b0, st4_r.a};
  assign dedr_nxt = st4_r.active ? kprod_c[65:16] : '0;

  // Stage 6: partial products of dE/dr split in two 25-bit halves.
  logic [24:0]       dh_c;
  logic [24:0]       dl_c;
  logic [58:0]       eh_r;
  logic [58:0]       el_r;
  logic [58:0]       th_r;
  logic [58:0]       tl_r;
  logic [2:0][57:0]  fh_r;
  logic [2:0][57:0]  fl_r;
  reg_st_t           st6_r;
  logic              v6_r;

  assign dh_c = dedr_r[49:25];
  assign dl_c = dedr_r[24:0];

  // Stage 7: product recombination, energy terms capped at 47 bits and the
  // first-atom force signs.
  logic [83:0]      e1w_c;
  logic [83:0]      e2w_c;
  logic [46:0]      e1_nxt;
  logic [46:0]      e2_nxt;
  logic [2:0][82:0] p_nxt;
  logic [2:0]       neg_nxt;
  logic [46:0]      e1_r;
  logic [46:0]      e2_r;
  logic [2:0][82:0] p7_r;
  logic [2:0]       neg7_r;
  logic [32:0]      r7_r;
  logic             active7_r;
  logic             dneg7_r;
  logic             v7_r;

  always_comb begin
    e1w_c  = {eh_r, 25'b0} + 84'(el_r);
    e2w_c  = {th_r, 25'b0} + 84'(tl_r);
    e1_nxt = (|e1w_c[83:64]) ? MAG_MAX : e1w_c[63:17];
    if (st6_r.harm) begin
      e2_nxt = '0;
    end else begin
      e2_nxt = (|e2w_c[83:63]) ? MAG_MAX : e2w_c[62:16];
    end
    for (int i = 0; i < 3; i++) begin
      p_nxt[i]   = {fh_r[i], 25'b0} + 83'(fl_r[i]);
      // Attractive pulls the first atom toward the second: coefficient -dE/dr.
      neg_nxt[i] = (st6_r.dneg != !repulsive_r) != st6_r.g.dsgn[i];
    end
  end

  // Stage 8: net energy, clamped to the 47-bit range.
  logic signed [48:0] es_c;
  div_side_t          side8_nxt;
  div_side_t          side8_r;
  logic [2:0][82:0]   p8_r;
  logic [32:0]        r8_r;
  logic               v8_r;

  always_comb begin
    es_c = dneg7_r ? (signed'({2'b00, e1_r}) - signed'({2'b00, e2_r}))
                   : (signed'({2'b00, e1_r}) + signed'({2'b00, e2_r}));
    if (!active7_r || es_c[48]) begin
      side8_nxt.energy = '0;
    end else if (es_c[47]) begin
      side8_nxt.energy = MAG_MAX;
    end else begin
      side8_nxt.energy = es_c[46:0];
    end
    side8_nxt.neg = neg7_r;
  end

  // Valid bits of the stages in this file.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
      v7_r <= 1'b0;
      v8_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_ch.valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= sq_valid;
      v5_r <= v4_r;
      v6_r <= v5_r;
      v7_r <= v6_r;
      v8_r <= v7_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      g1_r <= g1_nxt;
      for (int i = 0; i < 3; i++) begin
        sq_r[i] <= sqw_c[i][62:0];
        fh_r[i] <= 58'(dh_c) * 58'(st5_r.g.dm[i]);
        fl_r[i] <= 58'(dl_c) * 58'(st5_r.g.dm[i]);
      end
      eh_r      <= 59'(dh_c) * 59'(st5_r.a);
      el_r      <= 59'(dl_c) * 59'(st5_r.a);
      th_r      <= 59'(dh_c) * 59'(st5_r.t);
      tl_r      <= 59'(dl_c) * 59'(st5_r.t);
      g2_r      <= g1_r;
      sum_r     <= {1'b0, sq_r[0]} + {1'b0, sq_r[1]} + {1'b0, sq_r[2]};
      g3_r      <= g2_r;
      st4_r     <= st4_nxt;
      dedr_r    <= dedr_nxt;
      st5_r     <= st4_r;
      st6_r     <= st5_r;
      e1_r      <= e1_nxt;
      e2_r      <= e2_nxt;
      p7_r      <= p_nxt;
      neg7_r    <= neg_nxt;
      r7_r      <= st6_r.r;
      active7_r <= st6_r.active;
      dneg7_r   <= st6_r.dneg;
      side8_r   <= side8_nxt;
      p8_r      <= p7_r;
      r8_r      <= r7_r;
    end
  end

  // Force magnitudes |dE/dr * d| / r, saturated; zero distance gives zero.
  logic [2:0][46:0] dv_mag;
  div_side_t        dv_side;

  fbdr_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v8_r),
    .in_prod   (p8_r),
    .in_den    (r8_r),
    .in_side   (side8_r),
    .out_valid (dv_last),
    .out_mag   (dv_mag),
    .out_side  (dv_side)
  );

  // Output stage: holds one pair and sends it as two beats.
  logic [2:0][46:0] out_mag_r;
  logic [2:0]       out_neg_r;
  logic [46:0]      out_energy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      out_second_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r  <= dv_last;
      out_second_r <= 1'b0;
    end else if (out_ch.ready) begin
      out_second_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_mag_r    <= dv_mag;
      out_neg_r    <= dv_side.neg;
      out_energy_r <= dv_side.energy;
    end
  end

  function automatic logic signed [47:0] to_force(logic [46:0] m, logic ng);
    return ng ? -signed'({1'b0, m}) : signed'({1'b0, m});
  endfunction

  assign out_ch.valid      = out_valid_r;
  assign out_ch.last       = out_second_r;
  assign out_ch.atom_index = out_second_r ? second_atom_r : first_atom_r;
  assign out_ch.energy     = out_second_r ? '0 : out_energy_r;
  assign out_ch.force_x    = to_force(out_mag_r[0], out_neg_r[0] ^ out_second_r);
  assign out_ch.force_y    = to_force(out_mag_r[1], out_neg_r[1] ^ out_second_r);
  assign out_ch.force_z    = to_force(out_mag_r[2], out_neg_r[2] ^ out_second_r);

  // A taken first beat is always followed by the second beat of the pair.
  a_pair_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.last && out_ch.ready |=> out_ch.valid && out_ch.last)
    else $error("second beat of a pair did not follow its first beat");

  // Input back-pressure only while a finished pair waits behind a busy output.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> dv_last && out_ch.valid)
    else $error("input stalled without a waiting pair");

  // Saturated forces never reach the most negative 48-bit code.
  a_force_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.force_x != 48'h8000_0000_0000 &&
                     out_ch.force_y != 48'h8000_0000_0000 &&
                     out_ch.force_z != 48'h8000_0000_0000)
    else $error("force outside the saturated range");

endmodule

### verif/fbdr_scoreboard.sv
// ----------------------------------------------------------------------------
// fbdr_scoreboard
// Watches the configuration port and both channels of the flat-bottom
// distance restraint block, predicts the two force beats of every accepted
// position beat and compares them, field by field, with the beats sent.
// ----------------------------------------------------------------------------
module fbdr_scoreboard import fbdr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  fbdr_in_if                    in_mon,
  fbdr_out_if                   out_mon,
  output int                    fail_count,
  output int                    pending,
  output int                    beats_checked
);

  localparam logic [63:0] FORCE_CAP  = 64'h0000_7FFF_FFFF_FFFF;
  localparam logic [63:0] ENERGY_CAP = 64'h0000_7FFF_FFFF_FFFF;
  localparam logic [63:0] DEDR_CAP   = 64'h4000_0000_0000_0000;

  typedef struct {
    logic [15:0]        atom;
    logic signed [47:0] fx;
    logic signed [47:0] fy;
    logic signed [47:0] fz;
    logic [46:0]        energy;
    logic               last;
  } force_beat_t;

  // Mirror of the register file.
  logic signed [31:0] bound_r0;
  logic signed [31:0] onset_r1;
  logic [31:0]        spring_k;
  logic               repulsive;
  logic [15:0]        atom_a;
  logic [15:0]        atom_b;

  force_beat_t expected_forces[$];

  function automatic logic [63:0] floor_sqrt(logic [63:0] v);
    logic [63:0] res, b;
    res = '0;
    b = 64'h1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // Product shifted down and capped.
  function automatic logic [63:0] scaled_product(logic [63:0] a, logic [63:0] b, int sh,
                                                 logic [63:0] cap);
    logic [127:0] p;
    p = {64'h0, a} * {64'h0, b};
    p = p >> sh;
    return (p > {64'h0, cap}) ? cap : p[63:0];
  endfunction

  function automatic logic [63:0] scaled_quotient(logic [63:0] a, logic [63:0] b,
                                                  logic [63:0] den);
    logic [127:0] p, q;
    p = {64'h0, a} * {64'h0, b};
    q = p / {64'h0, den};
    return (q > {64'h0, FORCE_CAP}) ? FORCE_CAP : q[63:0];
  endfunction

  task automatic predict_pair(input logic signed [31:0] pos [6]);
    logic signed [33:0] d [3];
    logic [32:0]        dm [3];
    logic [63:0]        m, sum, r, dedr, x, t, lm, fm;
    logic signed [65:0] rs, r0s, r1s, lev, ene, lin;
    logic               big, active, harm, dneg, neg;
    logic [47:0]        fmag;
    force_beat_t        fa, fb;
    big = 1'b0;
    sum = '0;
    dedr = '0;
    dneg = 1'b0;
    ene = '0;
    for (int i = 0; i < 3; i++) begin
      d[i] = {{2{pos[i][31]}}, pos[i]} - {{2{pos[i+3][31]}}, pos[i+3]};
      dm[i] = d[i] < 0 ? 33'(-d[i]) : 33'(d[i]);
      if (dm[i] >= 33'h0_8000_0000) big = 1'b1;
    end
    for (int i = 0; i < 3; i++) begin
      m = big ? 64'(dm[i] >> 1) : 64'(dm[i]);
      sum = sum + m * m;
    end
    r = floor_sqrt(sum);
    if (big) r = r << 1;
    rs  = $signed({2'b00, r});
    r0s = 66'(bound_r0);
    r1s = 66'(onset_r1);
    active = repulsive ? (rs < -r0s) : (rs > r0s);
    harm   = repulsive ? (rs > r1s) : (rs < r1s);
    if (active) begin
      if (harm) begin
        x = repulsive ? 64'(-r0s - rs) : 64'(rs - r0s);
        dedr = scaled_product(64'(spring_k), x, 16, DEDR_CAP);
        ene = $signed({2'b00, scaled_product(dedr, x, 17, ENERGY_CAP)});
      end else begin
        // Constant-force region: the lever may be negative when r1 sits on
        // the wrong side of r0, which flips the force and lowers the energy.
        lev = repulsive ? (-r0s - r1s) : (r1s - r0s);
        t = repulsive ? 64'(r1s - rs) : 64'(rs - r1s);
        dneg = lev < 0;
        lm = dneg ? 64'(-lev) : 64'(lev);
        dedr = scaled_product(64'(spring_k), lm, 16, DEDR_CAP);
        ene = $signed({2'b00, scaled_product(dedr, lm, 17, ENERGY_CAP)});
        lin = $signed({2'b00, scaled_product(dedr, t, 16, ENERGY_CAP)});
        ene = dneg ? ene - lin : ene + lin;
      end
      if (ene < 0) ene = '0;
      if (ene > $signed({2'b00, ENERGY_CAP})) ene = $signed({2'b00, ENERGY_CAP});
    end
    fa.atom = atom_a;
    fb.atom = atom_b;
    for (int i = 0; i < 3; i++) begin
      fm = '0;
      if (active && r != 0 && dedr != 0) fm = scaled_quotient(dedr, 64'(dm[i]), r);
      fmag = fm[47:0];
      neg = (dneg != !repulsive) != (d[i] < 0);
      case (i)
        0: begin fa.fx = neg ? -fmag : fmag; fb.fx = neg ? fmag : -fmag; end
        1: begin fa.fy = neg ? -fmag : fmag; fb.fy = neg ? fmag : -fmag; end
        default: begin fa.fz = neg ? -fmag : fmag; fb.fz = neg ? fmag : -fmag; end
      endcase
    end
    fa.energy = ene[46:0];
    fb.energy = '0;
    fa.last = 1'b0;
    fb.last = 1'b1;
    expected_forces = {expected_forces, fa, fb};
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t: beat %0d %s got %h expected %h", $realtime, beats_checked, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    logic signed [31:0] pos [6];
    force_beat_t        w;
    if (!rst_n) begin
      bound_r0 = '0;
      onset_r1 = '0;
      spring_k = '0;
      repulsive = 1'b0;
      atom_a = '0;
      atom_b = '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_LOWER_BOUND:  bound_r0 = cfg_data;
          REG_LINEAR_ONSET: onset_r1 = cfg_data;
          REG_FORCE_CONST:  spring_k = cfg_data;
          REG_REPULSIVE:    repulsive = cfg_data[0];
          REG_FIRST_ATOM:   atom_a = cfg_data[15:0];
          REG_SECOND_ATOM:  atom_b = cfg_data[15:0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) begin
        pos[0] = in_mon.first_x;
        pos[1] = in_mon.first_y;
        pos[2] = in_mon.first_z;
        pos[3] = in_mon.second_x;
        pos[4] = in_mon.second_y;
        pos[5] = in_mon.second_z;
        predict_pair(pos);
      end
      if (out_mon.valid && out_mon.ready) begin
        if (expected_forces.size() == 0) begin
          report_mismatch("unexpected beat", 64'(out_mon.atom_index), '0);
        end else begin
          w = expected_forces.pop_front();
          if (out_mon.atom_index !== w.atom)
            report_mismatch("atom_index", 64'(out_mon.atom_index), 64'(w.atom));
          if (out_mon.force_x !== w.fx)
            report_mismatch("force_x", 64'(out_mon.force_x), 64'(w.fx));
          if (out_mon.force_y !== w.fy)
            report_mismatch("force_y", 64'(out_mon.force_y), 64'(w.fy));
          if (out_mon.force_z !== w.fz)
            report_mismatch("force_z", 64'(out_mon.force_z), 64'(w.fz));
          if (out_mon.energy !== w.energy)
            report_mismatch("energy", 64'(out_mon.energy), 64'(w.energy));
          if (out_mon.last !== w.last)
            report_mismatch("last", 64'(out_mon.last), 64'(w.last));
        end
        beats_checked++;
      end
    end
    pending = expected_forces.size();
  end

endmodule

### verif/tb_flat_bottom_distance_restraint.sv
// ----------------------------------------------------------------------------
// tb_flat_bottom_distance_restraint
// Drives position beats and register settings into the flat-bottom distance
// restraint block; a scoreboard beside it checks every force beat.
// ----------------------------------------------------------------------------
module tb_flat_bottom_distance_restraint import fbdr_pkg::*;;

  // Index that names no register; writes to it must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  // Cycles without any accepted beat before the run is abandoned.
  localparam int STALL_LIMIT = 20000;
  // Quiet time after the last result, longer than the pipeline is deep.
  localparam int DRAIN_CYCLES = 120;
  localparam int SEGMENTS = 9;
  localparam int SEGMENT_ITEMS = 222;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  fbdr_in_if  in_ch ();
  fbdr_out_if out_ch ();

  int  fail_count, pending, beats_checked;
  int  tx_idle, rx_idle;
  int  pairs_sent, settings_used;
  int  quiet_cycles;
  logic in_fire;

  flat_bottom_distance_restraint i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  fbdr_scoreboard i_scoreboard (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_mon        (in_ch),
    .out_mon       (out_ch),
    .fail_count    (fail_count),
    .pending       (pending),
    .beats_checked (beats_checked)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Input handshakes are captured at the rising edge, before the block
  // updates anything, and read by the stimulus at the following falling edge.
  always @(posedge clk) begin
    in_fire <= in_ch.valid && in_ch.ready;
  end

  // The receiver drops ready at random, with a rate set per segment.
  always @(negedge clk) begin
    out_ch.ready <= rst_n && ($urandom_range(99) >= rx_idle);
  end

  // Watchdog: any beat on either channel resets the count.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == STALL_LIMIT) begin
        $display("watchdog: no beat for %0d cycles, %0d results outstanding",
                 STALL_LIMIT, pending);
        $display("flat_bottom_distance_restraint: mismatch");
        $finish;
      end
    end
  end

  // One position beat. The sender may idle first; valid then stays high
  // until the block takes the beat. Entered and left at a falling edge.
  task automatic send_positions(input logic [31:0] fx, input logic [31:0] fy,
                                input logic [31:0] fz, input logic [31:0] sx,
                                input logic [31:0] sy, input logic [31:0] sz);
    while ($urandom_range(99) < tx_idle) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.first_x  <= fx;
    in_ch.first_y  <= fy;
    in_ch.first_z  <= fz;
    in_ch.second_x <= sx;
    in_ch.second_y <= sy;
    in_ch.second_z <= sz;
    do @(negedge clk); while (!in_fire);
    pairs_sent++;
  endtask

  // The sender holds off until every predicted beat has arrived and the
  // pipeline has had time to empty; registers only change then.
  task automatic wait_for_idle();
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Writes all six registers on consecutive cycles, plus one write to an
  // unused index that the block has to ignore.
  task automatic load_restraint(input logic [31:0] r0, input logic [31:0] r1,
                                input logic [31:0] k, input logic rep,
                                input logic [15:0] a1, input logic [15:0] a2);
    logic [CFG_IDX_W-1:0] idx [7];
    logic [31:0]          val [7];
    idx = '{REG_LOWER_BOUND, REG_LINEAR_ONSET, REG_FORCE_CONST, REG_REPULSIVE,
            REG_FIRST_ATOM, REG_SECOND_ATOM, REG_UNUSED};
    val = '{r0, r1, k, {31'h0, rep}, {16'h0, a1}, {16'h0, a2}, $urandom()};
    wait_for_idle();
    for (int i = 0; i < 7; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      @(negedge clk);
    end
    cfg_we <= 1'b0;
    @(negedge clk);
    settings_used++;
  endtask

  // Bound or onset: mostly a few nanometers either side of zero, so that
  // random distances land in every region, sometimes anything at all.
  function automatic logic [31:0] pick_length();
    case ($urandom_range(9))
      0:       return $urandom();
      1:       return 32'h8000_0000;
      2:       return 32'h7FFF_FFFF;
      default: return 32'($signed($urandom_range(1 << 20)) - (1 << 19));
    endcase
  endfunction

  function automatic logic [31:0] pick_spring();
    case ($urandom_range(7))
      0:       return 32'hFFFF_FFFF;
      1:       return '0;
      2:       return $urandom();
      default: return $urandom_range(1 << 24);
    endcase
  endfunction

  // A random pair: most pairs sit a short, random distance apart around a
  // random point; some are fully random and some coincide.
  task automatic send_random_pair();
    logic [31:0] f [3];
    logic [31:0] s [3];
    int          span, kind;
    kind = $urandom_range(9);
    span = 1 << (16 + $urandom_range(7));
    for (int i = 0; i < 3; i++) begin
      f[i] = 32'($signed($urandom_range(1 << 30)) - (1 << 29));
      case (kind)
        0, 1:    begin f[i] = $urandom(); s[i] = $urandom(); end
        2:       s[i] = f[i];
        default: s[i] = f[i] + 32'($signed($urandom_range(2 * span)) - span);
      endcase
    end
    send_positions(f[0], f[1], f[2], s[0], s[1], s[2]);
  endtask

  initial begin
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    in_ch.valid  = 1'b0;
    in_ch.first_x  = '0;
    in_ch.first_y  = '0;
    in_ch.first_z  = '0;
    in_ch.second_x = '0;
    in_ch.second_y = '0;
    in_ch.second_z = '0;
    tx_idle      = 26;
    rx_idle      = 75;
    pairs_sent   = 0;
    settings_used = 0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part. With the reset registers k is zero: zero force and energy.
    send_positions(32'h0001_0000, '0, '0, '0, '0, '0);

    // Attractive: bound 1 nm, onset 3 nm, k = 100.
    load_restraint(32'h0001_0000, 32'h0003_0000, 32'h0064_0000, 1'b0, 16'h0001, 16'hFFFF);
    send_positions('0, '0, '0, '0, '0, '0);                       // coincident atoms
    send_positions(32'h0000_8000, '0, '0, '0, '0, '0);            // inside the flat bottom
    send_positions(32'h0001_0000, '0, '0, '0, '0, '0);            // exactly at the bound
    send_positions(32'h0002_0000, 32'hFFFF_0000, '0, '0, '0, '0); // harmonic
    send_positions('0, '0, 32'h0003_0000, '0, '0, '0);            // at the onset
    send_positions('0, '0, '0, 32'h0010_0000, 32'h0007_0000, '0); // linear
    send_positions(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                   32'h8000_0000, 32'h8000_0000, 32'h8000_0000);  // huge separation
    send_positions(32'h8000_0000, 32'h7FFF_FFFF, '0, 32'h7FFF_FFFF, 32'h8000_0000, '0);

    // Repulsive: threshold 2 nm, onset 0.5 nm.
    load_restraint(32'hFFFE_0000, 32'h0000_8000, 32'h0100_0000, 1'b1, 16'hABCD, 16'h0000);
    send_positions('0, '0, '0, '0, '0, '0);
    send_positions(32'h0000_4000, '0, '0, '0, '0, '0);            // linear, close in
    send_positions(32'h0001_0000, '0, '0, '0, '0, '0);            // harmonic
    send_positions(32'h0002_0000, '0, '0, '0, '0, '0);            // at the threshold
    send_positions(32'h0005_0000, '0, '0, '0, '0, '0);            // inactive

    // Onset below the bound: negative lever, clamped energy.
    load_restraint(32'h0004_0000, 32'h0001_0000, 32'h0200_0000, 1'b0, 16'h1234, 16'h4321);
    send_positions(32'h0005_0000, '0, '0, '0, '0, '0);
    send_positions(32'h0040_0000, '0, '0, '0, '0, '0);

    // Extremes: strongest spring, widest onset, saturating outputs.
    load_restraint(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0, 16'hFFFF, 16'hFFFF);
    send_positions(32'h7FFF_FFFF, '0, '0, 32'h8000_0000, '0, '0);
    send_positions(32'h0000_0001, '0, '0, '0, '0, '0);
    load_restraint(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1, 16'h0000, 16'hFFFF);
    send_positions(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                   32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_positions('0, '0, '0, '0, '0, 32'h0000_0001);

    // Random part: three idle patterns, three register settings each.
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      case (seg / 3)
        0:       begin tx_idle = 26; rx_idle = 75; end
        1:       begin tx_idle = 75; rx_idle = 26; end
        default: begin tx_idle = 0;  rx_idle = 0;  end
      endcase
      load_restraint(pick_length(), pick_length(), pick_spring(), 1'($urandom()),
                     16'($urandom()), 16'($urandom()));
      for (int n = 0; n < SEGMENT_ITEMS; n++) send_random_pair();
    end

    wait_for_idle();
    $display("%0d position pairs in %0d register settings, %0d force beats checked",
             pairs_sent, settings_used, beats_checked);
    $display("covered attractive and repulsive restraints, coincident and huge separations");
    if (fail_count == 0) begin
      $display("flat_bottom_distance_restraint: match");
    end else begin
      $display("flat_bottom_distance_restraint: mismatch");
    end
    $finish;
  end

endmodule
